// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bkrms_pkg.sv -----
package bkrms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQUARE_W   = 2 * SAMPLE_W;
    localparam int BLEN_W     = 17;
    localparam int INVD_W     = 25;
    localparam int SUM_W      = 47;
    localparam int FRAC_W     = 24;
    localparam int MEAN_FRAC  = 30;
    localparam int ROOT_W     = MEAN_FRAC / 2;
    localparam int RMS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = INVD_W;

    localparam logic [BLEN_W-1:0] MAX_BLOCK     = BLEN_W'(65536);
    localparam logic [BLEN_W-1:0] BLEN_RESET    = BLEN_W'(1);
    localparam logic [INVD_W-1:0] INVD_RESET    = INVD_W'(1) << FRAC_W;
    localparam logic [RMS_W-1:0]  RMS_SAT       = RMS_W'(1) << ROOT_W;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INV_DENSITY = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN,
        ST_SQRT,
        ST_EMIT
    } bkrms_state_t;

endpackage

// ----- rtl/block_rms_decimator.sv -----
// Block RMS decimator: each accepted item squares one signed Q1.15 sample into a
// saturating Q17.30 sum; after block_len samples the sum is scaled by inv_density
// (Q1.24) and its square root is emitted as unsigned Q1.15, saturating at 32768.
// An item flagged end_of_channel drops a partial block, or closes a full one with
// channel_end set. Items are taken one at a time: a sample that does not close a
// block runs the 25 iterations of the bit-serial multiplier for its square, and
// a closing sample adds a second 25-step multiply for the mean and a 15-step
// square root. A finished result waits in an output register
// while the next sample is already being taken. Configuration writes are always
// accepted and should be made only while the block is idle.
`include "assert_macros.svh"

module block_rms_decimator
    import bkrms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                  end_of_channel,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [RMS_W-1:0]      rms,
    output logic                  channel_end
);

    localparam int P_W = SUM_W + INVD_W;

    bkrms_state_t state_reg;
    bkrms_state_t state_next;

    logic [BLEN_W-1:0]   block_len_reg;
    logic [INVD_W-1:0]   inv_density_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [BLEN_W-1:0]   count_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                eoc_reg;
    logic                chan_end_reg;
    logic                sat_reg;
    logic [RMS_W-1:0]    rms_reg;

    logic [SAMPLE_W-1:0] sample_abs;
    logic [BLEN_W-1:0]   len_eff;
    logic [BLEN_W-1:0]   count_inc;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic                close_block;
    logic                in_accept;
    logic                out_free;
    logic                out_load;

    logic                mul_start;
    logic [SUM_W-1:0]    mul_a;
    logic [INVD_W-1:0]   mul_b;
    logic                mul_done;
    logic [P_W-1:0]      mul_product;
    logic                mean_sat;

    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;

    bkrms_smul #(
        .A_W (SUM_W),
        .B_W (INVD_W)
    ) u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    bkrms_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mul_product[FRAC_W +: MEAN_FRAC]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // datapath
    always_comb
    begin
        sample_abs = sample[SAMPLE_W-1] ? $unsigned(-sample) : $unsigned(sample);

        if (block_len_reg == '0)
        begin
            len_eff = BLEN_W'(1);
        end
        else if (block_len_reg > MAX_BLOCK)
        begin
            len_eff = MAX_BLOCK;
        end
        else
        begin
            len_eff = block_len_reg;
        end

        count_inc   = count_reg + BLEN_W'(1);
        close_block = (count_inc >= len_eff);
        sum_wide    = {1'b0, sum_reg} + {{(SUM_W+1-SQUARE_W){1'b0}}, mul_product[SQUARE_W-1:0]};
        sum_sat     = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        mean_sat    = |mul_product[P_W-1:FRAC_W+MEAN_FRAC];

        out_free = !out_valid_reg || !out_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = close_block ? ST_MEAN : ST_IDLE;
            end
            ST_MEAN:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall   = 1'b1;
        in_accept  = 1'b0;
        mul_start  = 1'b0;
        mul_a      = sum_sat;
        mul_b      = inv_density_reg;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                in_accept = in_valid;
                mul_start = in_valid;
                mul_a     = {{(SUM_W-SAMPLE_W){1'b0}}, sample_abs};
                mul_b     = {{(INVD_W-SAMPLE_W){1'b0}}, sample_abs};
            end
            ST_ACCUM:
            begin
                mul_start = close_block;
            end
            ST_MEAN:
            begin
                sqrt_start = mul_done;
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_len_reg   <= BLEN_RESET;
            inv_density_reg <= INVD_RESET;
            sum_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_BLOCK_LEN)
                begin
                    block_len_reg <= cfg_data[BLEN_W-1:0];
                end
                else if (cfg_index == REG_INV_DENSITY)
                begin
                    inv_density_reg <= cfg_data[INVD_W-1:0];
                end
            end
            if (state_reg == ST_ACCUM)
            begin
                if (close_block || eoc_reg)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_sat;
                    count_reg <= count_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            eoc_reg <= end_of_channel;
        end
        if (sqrt_start)
        begin
            sat_reg <= mean_sat;
        end
        if (out_load)
        begin
            chan_end_reg <= eoc_reg;
            rms_reg      <= sat_reg ? RMS_SAT : {{(RMS_W-ROOT_W){1'b0}}, sqrt_root};
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign rms         = rms_reg;
    assign channel_end = chan_end_reg;

    `ASSERT_NEXT(a_close_clears, clk, rst_n, (state_reg == ST_ACCUM) && close_block, (count_reg == '0) && (sum_reg == '0), "block close left count or sum")
    `ASSERT_NEXT(a_emit_loads, clk, rst_n, (state_reg == ST_EMIT) && out_free, out_valid_reg && (state_reg == ST_IDLE), "finished result not loaded")
    `ASSERT_IMPLIES(a_units_apart, clk, rst_n, mul_done, !sqrt_done, "multiplier and square root finished together")

endmodule

// ----- rtl/bkrms_smul.sv -----
`include "assert_macros.svh"

module bkrms_smul
    import bkrms_pkg::*;
#(
    parameter int A_W = SUM_W,
    parameter int B_W = INVD_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [P_W-1:0]   p_reg;
    logic [P_W-1:0]   p_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W-1:0]   addend;
    logic [A_W:0]     upper_sum;

    // shift-add, one multiplier bit per cycle, lsb first
    always_comb
    begin
        addend    = p_reg[0] ? a_reg : '0;
        upper_sum = {1'b0, p_reg[P_W-1:B_W]} + {1'b0, addend};
        p_next    = {upper_sum, p_reg[B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

    `ASSERT_IMPLIES(a_mul_start_idle, clk, rst_n, start, !busy_reg, "multiplier restarted while busy")

endmodule

// ----- rtl/bkrms_isqrt.sv -----
`include "assert_macros.svh"

module bkrms_isqrt
    import bkrms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MEAN_FRAC-1:0] radicand,
    output logic                 done,
    output logic [ROOT_W-1:0]    root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic [MEAN_FRAC-1:0] rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TRY_W-1:0]     rem_shift;
    logic [TRY_W-1:0]     trial;
    logic                 fits;

    // restoring square root, two radicand bits and one root bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[MEAN_FRAC-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[MEAN_FRAC-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_shift - trial) : rem_shift[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    `ASSERT_IMPLIES(a_sqrt_start_idle, clk, rst_n, start, !busy_reg, "square root restarted while busy")

endmodule

// ----- tb/tb.sv -----
module tb
    import bkrms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_WAIT      = 18;
    localparam int          LONG_HOLD     = 500;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          RANDOM_ITEMS  = 2000;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] FULL_POS = ~FULL_NEG;
    localparam logic [SUM_W-1:0]           SUM_LIMIT = '1;
    localparam longint unsigned            MEAN_ONE  = longint'(1) << MEAN_FRAC;

    typedef struct packed {
        logic [RMS_W-1:0] level;
        logic             closed_at_end;
    } block_level_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         end_of_channel;
    logic                         out_valid;
    logic                         out_stall;
    logic [RMS_W-1:0]             rms;
    logic                         channel_end;

    // predictor state
    logic [BLEN_W-1:0] len_setting;
    logic [INVD_W-1:0] recip_setting;
    logic [SUM_W-1:0]  energy_sum;
    logic [BLEN_W-1:0] energy_count;

    block_level_t levels_pending[$];

    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned error_count = 0;
    int unsigned samples_sent = 0;
    int unsigned levels_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned cycle_count = 0;

    block_rms_decimator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .end_of_channel (end_of_channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rms            (rms),
        .channel_end    (channel_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, levels_pending.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic logic [RMS_W-1:0] root_mean_square(input logic [SUM_W-1:0] sum,
                                                          input logic [INVD_W-1:0] recip);
        longint unsigned hi, lo, scale, mean, root, trial;
        hi    = 64'(sum >> FRAC_W);
        lo    = 64'(sum[FRAC_W-1:0]);
        scale = 64'(recip);
        mean  = hi * scale + ((lo * scale) >> FRAC_W);
        if (mean >= MEAN_ONE)
            return RMS_SAT;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= mean)
                root = trial;
        end
        return RMS_W'(root);
    endfunction

    function automatic void append_level(input block_level_t lvl);
        levels_pending.insert(levels_pending.size(), lvl);
    endfunction

    function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] value,
                                           input logic last);
        logic [BLEN_W-1:0] eff_len;
        longint unsigned   mag, total;
        block_level_t      lvl;
        eff_len = len_setting;
        if (eff_len == '0)
            eff_len = BLEN_W'(1);
        if (eff_len > MAX_BLOCK)
            eff_len = MAX_BLOCK;
        mag = (value < 0) ? -longint'(value) : longint'(value);
        total = longint'(energy_sum) + mag * mag;
        energy_sum = (total > SUM_LIMIT) ? SUM_LIMIT : SUM_W'(total);
        energy_count = energy_count + BLEN_W'(1);
        if (energy_count >= eff_len)
        begin
            lvl.level = root_mean_square(energy_sum, recip_setting);
            lvl.closed_at_end = last;
            append_level(lvl);
            energy_sum = '0;
            energy_count = '0;
        end
        if (last)
        begin
            energy_sum = '0;
            energy_count = '0;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return FULL_NEG;
            1: return FULL_POS;
            2, 3, 4, 5: return raw[SAMPLE_W-1:0];
            default: return $signed(raw[SAMPLE_W-1:0]) >>> raw[31:28];
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        int unsigned wait_cycles;
        wait_cycles = draw_wait(send_idle_on);
        if (wait_cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        sample <= value;
        end_of_channel <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_sample(value, last);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
                             input logic [CFG_DATA_W-1:0] reg_value);
        @(posedge clk);
        cfg_index <= reg_index;
        cfg_data <= reg_value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (reg_index)
            REG_BLOCK_LEN:   len_setting = reg_value[BLEN_W-1:0];
            REG_INV_DENSITY: recip_setting = reg_value[INVD_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // block may still be working on an item that yields no result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (levels_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : level_checker
        int unsigned  stall_left;
        int unsigned  hold_left;
        block_level_t want;
        stall_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (levels_pending.size() == 0)
                begin
                    $error("unexpected item: rms %0d channel_end %0b", rms, channel_end);
                    error_count++;
                end
                else
                begin
                    want = levels_pending.pop_front();
                    if (rms !== want.level)
                    begin
                        $error("rms: expected %0d, actual %0d", want.level, rms);
                        error_count++;
                    end
                    if (channel_end !== want.closed_at_end)
                    begin
                        $error("channel_end: expected %0b, actual %0b",
                               want.closed_at_end, channel_end);
                        error_count++;
                    end
                    levels_checked++;
                end
                stall_left = draw_wait(recv_idle_on);
            end
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic test_reset_defaults();
        send_sample('0, 1'b0);
        send_sample(FULL_POS, 1'b0);
        send_sample(FULL_NEG, 1'b1);
        send_sample('1, 1'b0);
    endtask

    task automatic test_zero_length();
        drain_results();
        write_reg(REG_BLOCK_LEN, '0);
        write_reg(REG_INV_DENSITY, INVD_RESET >> 1);
        send_sample(FULL_POS, 1'b0);
        send_sample(-16'sd12345, 1'b1);
    endtask

    task automatic test_zero_reciprocal();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(2));
        write_reg(REG_INV_DENSITY, '0);
        send_sample(FULL_NEG, 1'b0);
        send_sample(FULL_POS, 1'b0);
    endtask

    task automatic test_mean_saturation();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(1));
        write_reg(REG_INV_DENSITY, '1);
        send_sample(16'sd20000, 1'b0);
        send_sample(FULL_NEG, 1'b0);
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(2));
        write_reg(REG_INV_DENSITY, INVD_RESET);
        send_sample(16'sd30000, 1'b0);
        send_sample(-16'sd30000, 1'b0);
    endtask

    task automatic test_channel_end();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(4));
        write_reg(REG_INV_DENSITY, INVD_RESET >> 2);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd2000, 1'b1);
        send_sample(16'sd3000, 1'b0);
        send_sample(-16'sd4000, 1'b0);
        send_sample(16'sd5000, 1'b0);
        send_sample(-16'sd6000, 1'b1);
    endtask

    task automatic test_length_lowered();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(8));
        write_reg(REG_INV_DENSITY, INVD_RESET >> 3);
        repeat (5) send_sample(pick_sample(), 1'b0);
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(3));
        send_sample(pick_sample(), 1'b0);
    endtask

    task automatic test_oversize_length();
        drain_results();
        write_reg(REG_BLOCK_LEN, '1);
        write_reg(REG_INV_DENSITY, INVD_RESET);
        send_sample(FULL_POS, 1'b0);
        send_sample(FULL_NEG, 1'b1);
    endtask

    task automatic test_unknown_register();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(1));
        write_reg(REG_INV_DENSITY, INVD_RESET >> 1);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        send_sample(16'sd23170, 1'b0);
        send_sample(-16'sd777, 1'b1);
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        drain_results();
        write_reg(REG_BLOCK_LEN, CFG_DATA_W'(1));
        write_reg(REG_INV_DENSITY, INVD_RESET);
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_sample(pick_sample(), $urandom_range(0, 3) == 0);
        send_idle_on = 1'b1;
    endtask

    task automatic test_random_blocks();
        int unsigned       start, len, eff, blocks, stop;
        bit                broken;
        logic              last;
        logic [INVD_W-1:0] base, recip;
        logic [CFG_DATA_W-1:0] word;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(0, 7))
                0: len = 0;
                1, 2: len = $urandom_range(17, 64);
                default: len = $urandom_range(1, 16);
            endcase
            eff = (len == 0) ? 1 : len;
            base = INVD_W'((longint'(1) << FRAC_W) / eff);
            case ($urandom_range(0, 7))
                0: recip = INVD_W'($urandom);
                1: recip = INVD_RESET;
                2: recip = base;
                default: recip = base - INVD_W'($urandom_range(0, base / 3));
            endcase
            word = CFG_DATA_W'($urandom);
            word[BLEN_W-1:0] = BLEN_W'(len);
            write_reg(REG_BLOCK_LEN, word);
            write_reg(REG_INV_DENSITY, recip);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            blocks = (eff > 16) ? $urandom_range(1, 4) : $urandom_range(2, 12);
            repeat (blocks)
            begin
                broken = ($urandom_range(0, 9) == 0);
                stop = broken ? $urandom_range(1, eff) : eff;
                for (int unsigned pos = 1; pos <= stop; pos++)
                begin
                    if (pos == stop)
                        last = broken || ($urandom_range(0, 5) == 0);
                    else
                        last = ($urandom_range(0, 63) == 0);
                    send_sample(pick_sample(), last);
                end
            end
            // may leave a partial block behind for the next setting
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, eff)) send_sample(pick_sample(), 1'b0);
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        sample <= '0;
        end_of_channel <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BLOCK_LEN;
        cfg_data <= '0;
        len_setting = BLEN_RESET;
        recip_setting = INVD_RESET;
        energy_sum = '0;
        energy_count = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_length();
        test_zero_reciprocal();
        test_mean_saturation();
        test_channel_end();
        test_length_lowered();
        test_oversize_length();
        test_unknown_register();
        test_output_backpressure();
        test_random_blocks();
        drain_results();

        $display("%0d samples sent, %0d block levels checked", samples_sent, levels_checked);
        $display("%0d register writes, %0d mismatches", reg_writes, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
